### design/assert_macros.svh
// Assertion helpers for the shader block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PDS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define PDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### design/pds_pkg.sv
package pds_pkg;

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_PIXEL  = 2'd1;
   localparam logic [1:0] CMD_TEXEL  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [1:0] KIND_REQ     = 2'd0;
   localparam logic [1:0] KIND_COLOR   = 2'd1;
   localparam logic [1:0] KIND_DISCARD = 2'd2;

   localparam logic [1:0] REG_LIGHT_X = 2'd0;
   localparam logic [1:0] REG_LIGHT_Y = 2'd1;
   localparam logic [1:0] REG_LIGHT_Z = 2'd2;

   localparam logic [2:0] ELEM_U  = 3'd0;
   localparam logic [2:0] ELEM_V  = 3'd1;
   localparam logic [2:0] ELEM_NX = 3'd2;
   localparam logic [2:0] ELEM_NY = 3'd3;
   localparam logic [2:0] ELEM_NZ = 3'd4;

   localparam logic [1:0]  VTX_LAST   = 2'd2;
   localparam logic [4:0]  SQRT_LAST  = 5'd27;
   localparam logic [4:0]  DIV_LAST   = 5'd14;
   localparam logic [14:0] ONE_Q14    = 15'd16384;
   localparam logic [8:0]  COLOR_BIAS = 9'd5;
   localparam logic [8:0]  COLOR_MAX  = 9'd255;
   localparam logic signed [15:0] LIGHT_Z_RESET = -16'sd16384;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [1:0]         vertex_index;
      logic [15:0]        vert_u;
      logic [15:0]        vert_v;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic [15:0]        weight_0;
      logic [15:0]        weight_1;
      logic [15:0]        weight_2;
      logic [23:0]        texel_rgb;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [11:0] tex_u;
      logic [11:0] tex_v;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INTERP,
      ST_SQUARE,
      ST_DOT,
      ST_SQRT,
      ST_DIV_INIT,
      ST_DIV,
      ST_FINISH,
      ST_REQ_OUT,
      ST_SHADE,
      ST_COLOR_OUT
   } ctrl_state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_PIXEL,
      DP_TEXEL,
      DP_INTERP,
      DP_SQUARE,
      DP_DOT,
      DP_SQRT,
      DP_DIV_INIT,
      DP_DIV,
      DP_FINISH,
      DP_SHADE,
      DP_EMIT_REQ,
      DP_EMIT_COLOR
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [2:0] elem;
      logic [4:0] cnt;
   } dp_cmd_type;

   typedef struct packed {
      logic pending_valid;
      logic inten_zero;
   } dp_status_type;

endpackage

### design/phong_diffuse_pixel_shader_top.sv
// Channel   Ports                          Carries
// req       req_valid/req_ready/req_payload  load, pixel or texel item
// rsp       rsp_valid/rsp_ready/rsp_payload  texture request, color or discard
// csr       psel/penable/pwrite/paddr/...    light vector, Q1.14
//
// Texel item: a shade step per channel on one shared multiplier, then
// output; dropped with no pending pixel. Pixel item: 15 interpolation MACs,
// 6 MACs for |n|^2 and n.L, 28 rsqrt digit steps, divider init, a divider
// step per quotient bit, finish and output. Reset is synchronous and clears
// control and pending state. A held result stalls output until rsp_ready.
`include "assert_macros.svh"

module phong_diffuse_pixel_shader_top #(
   parameter int TEX_COORD_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pds_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output pds_pkg::rsp_payload_type rsp_payload,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [3:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   logic signed [15:0] light_x_ff, light_x_in;
   logic signed [15:0] light_y_ff, light_y_in;
   logic signed [15:0] light_z_ff, light_z_in;
   logic               csr_we;
   logic [1:0]         csr_index;
   pds_pkg::dp_cmd_type    dp_cmd;
   pds_pkg::dp_status_type dp_status;

   assign pready    = 1'b1;
   assign csr_we    = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   always_comb begin
      light_x_in = light_x_ff;
      light_y_in = light_y_ff;
      light_z_in = light_z_ff;
      if (csr_we) begin
         case (csr_index)
            pds_pkg::REG_LIGHT_X: light_x_in = pwdata[15:0];
            pds_pkg::REG_LIGHT_Y: light_y_in = pwdata[15:0];
            pds_pkg::REG_LIGHT_Z: light_z_in = pwdata[15:0];
            default:              light_x_in = light_x_ff;
         endcase
      end
      case (csr_index)
         pds_pkg::REG_LIGHT_X: prdata = {16'b0, light_x_ff};
         pds_pkg::REG_LIGHT_Y: prdata = {16'b0, light_y_ff};
         pds_pkg::REG_LIGHT_Z: prdata = {16'b0, light_z_ff};
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff <= '0;
         light_y_ff <= '0;
         light_z_ff <= pds_pkg::LIGHT_Z_RESET;
      end else begin
         light_x_ff <= light_x_in;
         light_y_ff <= light_y_in;
         light_z_ff <= light_z_in;
      end
   end

   pds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_payload.cmd),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .status    (dp_status),
      .dp_cmd    (dp_cmd)
   );

   pds_datapath #(
      .TEX_COORD_BITS (TEX_COORD_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (dp_cmd),
      .req_payload (req_payload),
      .light_x     (light_x_ff),
      .light_y     (light_y_ff),
      .light_z     (light_z_ff),
      .status      (dp_status),
      .rsp_payload (rsp_payload)
   );

   `PDS_ASSERT_IMPLY(a_kind_legal, clock, reset, rsp_valid, (rsp_payload.kind == pds_pkg::KIND_REQ) || (rsp_payload.kind == pds_pkg::KIND_COLOR) || (rsp_payload.kind == pds_pkg::KIND_DISCARD))
   `PDS_ASSERT_IMPLY(a_discard_blank, clock, reset, rsp_valid && (rsp_payload.kind == pds_pkg::KIND_DISCARD), (rsp_payload.red == 8'd0) && (rsp_payload.green == 8'd0) && (rsp_payload.blue == 8'd0) && (rsp_payload.tex_u == 12'd0))
   `PDS_ASSERT_IMPLY(a_color_biased, clock, reset, rsp_valid && (rsp_payload.kind == pds_pkg::KIND_COLOR), (rsp_payload.red >= 8'd5) && (rsp_payload.green >= 8'd5) && (rsp_payload.blue >= 8'd5))
   `PDS_ASSERT_NEXT(a_pixel_busy, clock, reset, req_valid && req_ready && (req_payload.cmd == pds_pkg::CMD_PIXEL), !req_ready)

endmodule

### design/pds_ctrl.sv
module pds_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_cmd,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   input  pds_pkg::dp_status_type status,
   output pds_pkg::dp_cmd_type    dp_cmd
);

   pds_pkg::ctrl_state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [2:0] elem_ff, elem_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       emit;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      elem_in  = elem_ff;
      case (state_ff)
         pds_pkg::ST_IDLE: begin
            cnt_in  = '0;
            elem_in = pds_pkg::ELEM_U;
            if (req_valid) begin
               case (req_cmd)
                  pds_pkg::CMD_PIXEL: state_in = pds_pkg::ST_INTERP;
                  pds_pkg::CMD_TEXEL: begin
                     if (status.pending_valid) begin
                        state_in = status.inten_zero ? pds_pkg::ST_COLOR_OUT
                                                     : pds_pkg::ST_SHADE;
                     end
                  end
                  default: state_in = pds_pkg::ST_IDLE;
               endcase
            end
         end
         pds_pkg::ST_INTERP: begin
            if (cnt_ff[1:0] == pds_pkg::VTX_LAST) begin
               cnt_in = '0;
               if (elem_ff == pds_pkg::ELEM_NZ) begin
                  state_in = pds_pkg::ST_SQUARE;
               end else begin
                  elem_in = elem_ff + 3'd1;
               end
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         pds_pkg::ST_SQUARE: begin
            if (cnt_ff[1:0] == pds_pkg::VTX_LAST) begin
               cnt_in   = '0;
               state_in = pds_pkg::ST_DOT;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         pds_pkg::ST_DOT: begin
            if (cnt_ff[1:0] == pds_pkg::VTX_LAST) begin
               cnt_in   = '0;
               state_in = pds_pkg::ST_SQRT;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         pds_pkg::ST_SQRT: begin
            if (cnt_ff == pds_pkg::SQRT_LAST) begin
               cnt_in   = '0;
               state_in = pds_pkg::ST_DIV_INIT;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         pds_pkg::ST_DIV_INIT: state_in = pds_pkg::ST_DIV;
         pds_pkg::ST_DIV: begin
            if (cnt_ff == pds_pkg::DIV_LAST) begin
               cnt_in   = '0;
               state_in = pds_pkg::ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         pds_pkg::ST_FINISH: state_in = pds_pkg::ST_REQ_OUT;
         pds_pkg::ST_REQ_OUT: begin
            if (out_free) state_in = pds_pkg::ST_IDLE;
         end
         pds_pkg::ST_SHADE: begin
            if (cnt_ff[1:0] == pds_pkg::VTX_LAST) begin
               cnt_in   = '0;
               state_in = pds_pkg::ST_COLOR_OUT;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         pds_pkg::ST_COLOR_OUT: begin
            if (out_free) state_in = pds_pkg::ST_IDLE;
         end
         default: state_in = pds_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      dp_cmd.op   = pds_pkg::DP_NOP;
      dp_cmd.elem = elem_ff;
      dp_cmd.cnt  = cnt_ff;
      case (state_ff)
         pds_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_cmd)
                  pds_pkg::CMD_LOAD:  dp_cmd.op = pds_pkg::DP_LOAD;
                  pds_pkg::CMD_PIXEL: dp_cmd.op = pds_pkg::DP_PIXEL;
                  pds_pkg::CMD_TEXEL: begin
                     if (status.pending_valid) dp_cmd.op = pds_pkg::DP_TEXEL;
                  end
                  default: dp_cmd.op = pds_pkg::DP_NOP;
               endcase
            end
         end
         pds_pkg::ST_INTERP:   dp_cmd.op = pds_pkg::DP_INTERP;
         pds_pkg::ST_SQUARE:   dp_cmd.op = pds_pkg::DP_SQUARE;
         pds_pkg::ST_DOT:      dp_cmd.op = pds_pkg::DP_DOT;
         pds_pkg::ST_SQRT:     dp_cmd.op = pds_pkg::DP_SQRT;
         pds_pkg::ST_DIV_INIT: dp_cmd.op = pds_pkg::DP_DIV_INIT;
         pds_pkg::ST_DIV:      dp_cmd.op = pds_pkg::DP_DIV;
         pds_pkg::ST_FINISH:   dp_cmd.op = pds_pkg::DP_FINISH;
         pds_pkg::ST_SHADE:    dp_cmd.op = pds_pkg::DP_SHADE;
         pds_pkg::ST_REQ_OUT: begin
            if (out_free) dp_cmd.op = pds_pkg::DP_EMIT_REQ;
         end
         pds_pkg::ST_COLOR_OUT: begin
            if (out_free) dp_cmd.op = pds_pkg::DP_EMIT_COLOR;
         end
         default: dp_cmd.op = pds_pkg::DP_NOP;
      endcase
   end

   assign emit = (dp_cmd.op == pds_pkg::DP_EMIT_REQ) || (dp_cmd.op == pds_pkg::DP_EMIT_COLOR);

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pds_pkg::ST_IDLE;
         cnt_ff       <= '0;
         elem_ff      <= pds_pkg::ELEM_U;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         elem_ff      <= elem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### design/pds_datapath.sv
module pds_datapath #(
   parameter int TEX_COORD_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pds_pkg::dp_cmd_type      cmd,
   input  pds_pkg::req_payload_type req_payload,
   input  logic signed [15:0]       light_x,
   input  logic signed [15:0]       light_y,
   input  logic signed [15:0]       light_z,
   output pds_pkg::dp_status_type   status,
   output pds_pkg::rsp_payload_type rsp_payload
);

   localparam logic [16:0] TC_LIMIT = 17'((1 << TEX_COORD_BITS) - 1);

   logic [15:0]        u_store_ff[3],  u_store_in[3];
   logic [15:0]        v_store_ff[3],  v_store_in[3];
   logic signed [15:0] nx_store_ff[3], nx_store_in[3];
   logic signed [15:0] ny_store_ff[3], ny_store_in[3];
   logic signed [15:0] nz_store_ff[3], nz_store_in[3];
   logic [15:0]        w_ff[3], w_in[3];
   logic [23:0]        texel_ff, texel_in;
   logic signed [39:0] acc_ff, acc_in;
   logic [TEX_COORD_BITS-1:0] tu_ff, tu_in, tv_ff, tv_in;
   logic signed [17:0] n_ff[3], n_in[3];
   logic [35:0]        sq_ff, sq_in;
   logic signed [35:0] d_ff, d_in;
   logic [56:0]        x_ff, x_in, res_ff, res_in, bit_ff, bit_in;
   logic [45:0]        rem_ff, rem_in, dv_ff, dv_in;
   logic [14:0]        q_ff, q_in;
   logic               sat_ff, sat_in, zero_ff, zero_in;
   logic [14:0]        inten_ff, inten_in;
   logic               pending_ff, pending_in;
   logic [7:0]         color_ff[3], color_in[3];
   pds_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [1:0]         idx;
   logic signed [18:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [36:0] prod;
   logic signed [39:0] acc_sum;
   logic [16:0]        tc_sh, tc_sat;
   logic signed [15:0] light_sel;
   logic [7:0]         chan;
   logic [8:0]         cv;
   logic [56:0]        sq_t;
   logic [28:0]        s_root;
   logic [35:0]        neg_d;
   logic [45:0]        num;
   logic [15:0]        tu_w, tv_w;

   assign idx = cmd.cnt[1:0];

   always_comb begin
      case (idx)
         2'd0:    light_sel = light_x;
         2'd1:    light_sel = light_y;
         default: light_sel = light_z;
      endcase
      case (idx)
         2'd0:    chan = texel_ff[23:16];
         2'd1:    chan = texel_ff[15:8];
         default: chan = texel_ff[7:0];
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         pds_pkg::DP_INTERP: begin
            mul_b = signed'({2'b00, w_ff[idx]});
            case (cmd.elem)
               pds_pkg::ELEM_U:  mul_a = signed'({3'b000, u_store_ff[idx]});
               pds_pkg::ELEM_V:  mul_a = signed'({3'b000, v_store_ff[idx]});
               pds_pkg::ELEM_NX: mul_a = 19'(nx_store_ff[idx]);
               pds_pkg::ELEM_NY: mul_a = 19'(ny_store_ff[idx]);
               default:          mul_a = 19'(nz_store_ff[idx]);
            endcase
         end
         pds_pkg::DP_SQUARE: begin
            mul_a = 19'(n_ff[idx]);
            mul_b = n_ff[idx];
         end
         pds_pkg::DP_DOT: begin
            mul_a = 19'(n_ff[idx]);
            mul_b = 18'(light_sel);
         end
         pds_pkg::DP_SHADE: begin
            mul_a = signed'({11'b0, chan});
            mul_b = signed'({3'b000, inten_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod    = 37'(mul_a) * 37'(mul_b);
   assign acc_sum = ((idx == 2'd0) ? 40'sd0 : acc_ff) + 40'(prod);
   assign tc_sh   = {2'b00, acc_sum[33:19]};
   assign tc_sat  = (tc_sh > TC_LIMIT) ? TC_LIMIT : tc_sh;
   assign sq_t    = res_ff + bit_ff;
   assign s_root  = res_ff[28:0];
   assign neg_d   = 36'(-d_ff);
   assign num     = {neg_d, 10'b0};
   assign cv      = {1'b0, prod[21:14]} + pds_pkg::COLOR_BIAS;
   assign tu_w    = 16'(tu_ff);
   assign tv_w    = 16'(tv_ff);

   always_comb begin
      u_store_in  = u_store_ff;
      v_store_in  = v_store_ff;
      nx_store_in = nx_store_ff;
      ny_store_in = ny_store_ff;
      nz_store_in = nz_store_ff;
      w_in        = w_ff;
      texel_in    = texel_ff;
      acc_in      = acc_ff;
      tu_in       = tu_ff;
      tv_in       = tv_ff;
      n_in        = n_ff;
      sq_in       = sq_ff;
      d_in        = d_ff;
      x_in        = x_ff;
      res_in      = res_ff;
      bit_in      = bit_ff;
      rem_in      = rem_ff;
      dv_in       = dv_ff;
      q_in        = q_ff;
      sat_in      = sat_ff;
      zero_in     = zero_ff;
      inten_in    = inten_ff;
      pending_in  = pending_ff;
      color_in    = color_ff;
      rsp_in      = rsp_ff;
      case (cmd.op)
         pds_pkg::DP_LOAD: begin
            if (req_payload.vertex_index != 2'd3) begin
               u_store_in[req_payload.vertex_index]  = req_payload.vert_u;
               v_store_in[req_payload.vertex_index]  = req_payload.vert_v;
               nx_store_in[req_payload.vertex_index] = req_payload.normal_x;
               ny_store_in[req_payload.vertex_index] = req_payload.normal_y;
               nz_store_in[req_payload.vertex_index] = req_payload.normal_z;
            end
         end
         pds_pkg::DP_PIXEL: begin
            w_in[0] = req_payload.weight_0;
            w_in[1] = req_payload.weight_1;
            w_in[2] = req_payload.weight_2;
         end
         pds_pkg::DP_TEXEL: begin
            texel_in   = req_payload.texel_rgb;
            pending_in = 1'b0;
         end
         pds_pkg::DP_INTERP: begin
            acc_in = acc_sum;
            if (idx == pds_pkg::VTX_LAST) begin
               case (cmd.elem)
                  pds_pkg::ELEM_U:  tu_in   = tc_sat[TEX_COORD_BITS-1:0];
                  pds_pkg::ELEM_V:  tv_in   = tc_sat[TEX_COORD_BITS-1:0];
                  pds_pkg::ELEM_NX: n_in[0] = acc_sum[32:15];
                  pds_pkg::ELEM_NY: n_in[1] = acc_sum[32:15];
                  default:          n_in[2] = acc_sum[32:15];
               endcase
            end
         end
         pds_pkg::DP_SQUARE: begin
            acc_in = acc_sum;
            if (idx == pds_pkg::VTX_LAST) sq_in = acc_sum[35:0];
         end
         pds_pkg::DP_DOT: begin
            acc_in = acc_sum;
            if (idx == pds_pkg::VTX_LAST) begin
               d_in   = acc_sum[35:0];
               x_in   = {1'b0, sq_ff, 20'b0};
               res_in = '0;
               bit_in = 57'(1) << 54;
            end
         end
         pds_pkg::DP_SQRT: begin
            if (x_ff >= sq_t) begin
               x_in   = x_ff - sq_t;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         pds_pkg::DP_DIV_INIT: begin
            zero_in = !d_ff[35] || (s_root == '0);
            rem_in  = num;
            dv_in   = {3'b000, s_root, 14'b0};
            sat_in  = num >= {2'b00, s_root, 15'b0};
            q_in    = '0;
         end
         pds_pkg::DP_DIV: begin
            if (rem_ff >= dv_ff) begin
               rem_in = rem_ff - dv_ff;
               q_in   = {q_ff[13:0], 1'b1};
            end else begin
               q_in   = {q_ff[13:0], 1'b0};
            end
            dv_in = dv_ff >> 1;
         end
         pds_pkg::DP_FINISH: begin
            if (zero_ff) begin
               inten_in = '0;
            end else if (sat_ff || (q_ff > pds_pkg::ONE_Q14)) begin
               inten_in = pds_pkg::ONE_Q14;
            end else begin
               inten_in = q_ff;
            end
            pending_in = 1'b1;
         end
         pds_pkg::DP_SHADE: begin
            color_in[idx] = (cv > pds_pkg::COLOR_MAX) ? 8'hFF : cv[7:0];
         end
         pds_pkg::DP_EMIT_REQ: begin
            rsp_in.kind  = pds_pkg::KIND_REQ;
            rsp_in.tex_u = tu_w[11:0];
            rsp_in.tex_v = tv_w[11:0];
            rsp_in.red   = '0;
            rsp_in.green = '0;
            rsp_in.blue  = '0;
         end
         pds_pkg::DP_EMIT_COLOR: begin
            rsp_in.tex_u = '0;
            rsp_in.tex_v = '0;
            if (inten_ff == '0) begin
               rsp_in.kind  = pds_pkg::KIND_DISCARD;
               rsp_in.red   = '0;
               rsp_in.green = '0;
               rsp_in.blue  = '0;
            end else begin
               rsp_in.kind  = pds_pkg::KIND_COLOR;
               rsp_in.red   = color_ff[0];
               rsp_in.green = color_ff[1];
               rsp_in.blue  = color_ff[2];
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         inten_ff   <= '0;
      end else begin
         pending_ff <= pending_in;
         inten_ff   <= inten_in;
      end
   end

   always_ff @(posedge clock) begin
      u_store_ff  <= u_store_in;
      v_store_ff  <= v_store_in;
      nx_store_ff <= nx_store_in;
      ny_store_ff <= ny_store_in;
      nz_store_ff <= nz_store_in;
      w_ff        <= w_in;
      texel_ff    <= texel_in;
      acc_ff      <= acc_in;
      tu_ff       <= tu_in;
      tv_ff       <= tv_in;
      n_ff        <= n_in;
      sq_ff       <= sq_in;
      d_ff        <= d_in;
      x_ff        <= x_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      rem_ff      <= rem_in;
      dv_ff       <= dv_in;
      q_ff        <= q_in;
      sat_ff      <= sat_in;
      zero_ff     <= zero_in;
      color_ff    <= color_in;
      rsp_ff      <= rsp_in;
   end

   assign status.pending_valid = pending_ff;
   assign status.inten_zero    = (inten_ff == '0);
   assign rsp_payload          = rsp_ff;

endmodule

### test/testbench.sv
module testbench;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   pds_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   pds_pkg::rsp_payload_type rsp_payload;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [3:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   phong_diffuse_pixel_shader_top dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   logic signed [15:0] lx, ly, lz;
   logic [15:0] su [3], sv [3];
   logic signed [15:0] snx [3], sny [3], snz [3];
   logic [16:0] held_inten;
   logic held_valid;

   pds_pkg::rsp_payload_type shade_queue [$];
   int errors = 0;
   int cycles = 0;
   int send_idle = 0, recv_stall = 0;

   localparam int LIMIT = 2000000;

   function automatic logic [11:0] tex_coord(logic [15:0] c [3], logic [15:0] w [3]);
      logic [63:0] acc;
      acc = 0;
      for (int i = 0; i < 3; i++) acc += 64'(c[i]) * 64'(w[i]);
      acc >>= 19;
      return acc > 64'd4095 ? 12'd4095 : acc[11:0];
   endfunction

   function automatic longint normal_lerp(logic signed [15:0] c [3], logic [15:0] w [3]);
      longint acc;
      acc = 0;
      for (int i = 0; i < 3; i++) acc += longint'(c[i]) * longint'(w[i]);
      if (acc >= 0) return acc / 32768;
      return -((-acc + 32767) / 32768);
   endfunction

   function automatic longint unsigned root(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [7:0] channel(logic [7:0] c, logic [16:0] k);
      longint unsigned t;
      t = ((64'(c) * 64'(k)) >> 14) + 5;
      return t > 255 ? 8'd255 : t[7:0];
   endfunction

   // returns 1 when the item yields a result
   function automatic bit shade_predict(pds_pkg::req_payload_type p,
                                        output pds_pkg::rsp_payload_type r);
      logic [15:0] w [3];
      longint nx, ny, nz, d;
      longint unsigned s, k;
      r = '0;
      case (p.cmd)
         pds_pkg::CMD_LOAD: begin
            if (p.vertex_index < 3) begin
               su[p.vertex_index] = p.vert_u;
               sv[p.vertex_index] = p.vert_v;
               snx[p.vertex_index] = p.normal_x;
               sny[p.vertex_index] = p.normal_y;
               snz[p.vertex_index] = p.normal_z;
            end
            return 0;
         end
         pds_pkg::CMD_PIXEL: begin
            w[0] = p.weight_0; w[1] = p.weight_1; w[2] = p.weight_2;
            r.kind = pds_pkg::KIND_REQ;
            r.tex_u = tex_coord(su, w);
            r.tex_v = tex_coord(sv, w);
            nx = normal_lerp(snx, w);
            ny = normal_lerp(sny, w);
            nz = normal_lerp(snz, w);
            s = root(64'(nx * nx + ny * ny + nz * nz) << 20);
            d = nx * longint'(lx) + ny * longint'(ly) + nz * longint'(lz);
            k = 0;
            if (d < 0 && s != 0) begin
               k = (64'(-d) << 10) / s;
               if (k > 16384) k = 16384;
            end
            held_inten = k[16:0];
            held_valid = 1;
            return 1;
         end
         pds_pkg::CMD_TEXEL: begin
            if (!held_valid) return 0;
            held_valid = 0;
            if (held_inten == 0) begin
               r.kind = pds_pkg::KIND_DISCARD;
               return 1;
            end
            r.kind = pds_pkg::KIND_COLOR;
            r.red = channel(p.texel_rgb[23:16], held_inten);
            r.green = channel(p.texel_rgb[15:8], held_inten);
            r.blue = channel(p.texel_rgb[7:0], held_inten);
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (shade_queue.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected item %p", rsp_payload);
         end else begin
            pds_pkg::rsp_payload_type e;
            e = shade_queue.pop_front();
            if (e !== rsp_payload) begin
               errors++;
               if (errors <= 10) $display("mismatch exp %p got %p", e, rsp_payload);
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall);
   end

   task automatic csr_write(logic [1:0] idx, logic signed [15:0] val);
      @(negedge clock);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= {idx, 2'b00};
      pwdata <= {{16{val[15]}}, val};
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      case (idx)
         pds_pkg::REG_LIGHT_X: lx = val;
         pds_pkg::REG_LIGHT_Y: ly = val;
         default: lz = val;
      endcase
   endtask

   // called at a falling edge right after the last send
   task automatic drain;
      req_valid <= 0;
      while (shade_queue.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // entered at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so the next item can follow without a gap
   task automatic send(pds_pkg::req_payload_type p, bit has_fixed = 0,
                       pds_pkg::rsp_payload_type fixed = '0);
      pds_pkg::rsp_payload_type r;
      bit got;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      got = shade_predict(p, r);
      if (got) shade_queue.push_back(has_fixed ? fixed : r);
      @(negedge clock);
   endtask

   function automatic pds_pkg::req_payload_type load_item(logic [1:0] k, logic [15:0] u,
         logic [15:0] v, logic [15:0] x, logic [15:0] y, logic [15:0] z);
      pds_pkg::req_payload_type p;
      p = '0;
      p.cmd = pds_pkg::CMD_LOAD; p.vertex_index = k;
      p.vert_u = u; p.vert_v = v;
      p.normal_x = x; p.normal_y = y; p.normal_z = z;
      return p;
   endfunction

   function automatic pds_pkg::req_payload_type pixel_item(logic [15:0] a, logic [15:0] b,
         logic [15:0] c);
      pds_pkg::req_payload_type p;
      p = 156'($urandom);
      p.cmd = pds_pkg::CMD_PIXEL;
      p.weight_0 = a; p.weight_1 = b; p.weight_2 = c;
      return p;
   endfunction

   function automatic pds_pkg::req_payload_type texel_item(logic [23:0] t);
      pds_pkg::req_payload_type p;
      p = 156'({$urandom, $urandom, $urandom, $urandom, $urandom});
      p.cmd = pds_pkg::CMD_TEXEL;
      p.texel_rgb = t;
      return p;
   endfunction

   function automatic logic [15:0] rnd_weight();
      return (($urandom_range(9) == 0) ? 16'd32768 : 16'($urandom_range(32768)));
   endfunction

   task automatic random_phase(int n);
      pds_pkg::req_payload_type p;
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < 20) begin
            p = 156'({$urandom, $urandom, $urandom, $urandom, $urandom});
            p.cmd = pds_pkg::CMD_LOAD;
            if ($urandom_range(9) == 0) p.vertex_index = 2'd3;
            else p.vertex_index = 2'($urandom_range(2));
         end else if (sel < 55) begin
            p = pixel_item(rnd_weight(), rnd_weight(), rnd_weight());
         end else if (sel < 92) begin
            p = texel_item(24'($urandom));
         end else begin
            p = 156'({$urandom, $urandom, $urandom, $urandom, $urandom});
            p.cmd = pds_pkg::CMD_UNUSED;
         end
         send(p);
      end
   endtask

   initial begin
      pds_pkg::req_payload_type tbl [$];
      pds_pkg::rsp_payload_type fx [$];
      bit hf [$];
      pds_pkg::rsp_payload_type r0;
      lx = 0; ly = 0; lz = pds_pkg::LIGHT_Z_RESET;
      held_inten = 0; held_valid = 0;
      for (int i = 0; i < 3; i++) begin
         su[i] = 0; sv[i] = 0; snx[i] = 0; sny[i] = 0; snz[i] = 0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed table
      r0 = '0;
      tbl.push_back(texel_item(24'hFFFFFF)); hf.push_back(0); fx.push_back(r0);
      tbl.push_back(load_item(2'd0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h8000));
      tbl.push_back(load_item(2'd1, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h0000, 16'h0000));
      tbl.push_back(load_item(2'd2, 16'h1234, 16'h8000, 16'h0000, 16'h8000, 16'h7FFF));
      tbl.push_back(load_item(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      repeat (4) begin hf.push_back(0); fx.push_back(r0); end
      tbl.push_back(pixel_item(16'd32768, 16'd0, 16'd0)); hf.push_back(0); fx.push_back(r0);
      tbl.push_back(texel_item(24'hFFFFFF)); hf.push_back(0); fx.push_back(r0);
      tbl.push_back(pixel_item(16'd0, 16'd32768, 16'd0)); hf.push_back(0); fx.push_back(r0);
      r0 = '0; r0.kind = pds_pkg::KIND_DISCARD;
      tbl.push_back(texel_item(24'h000000)); hf.push_back(1); fx.push_back(r0);
      r0 = '0;
      tbl.push_back(pixel_item(16'd32768, 16'd32768, 16'd32768));
      hf.push_back(0); fx.push_back(r0);
      tbl.push_back(pixel_item(16'd16384, 16'd16384, 16'd0));
      hf.push_back(0); fx.push_back(r0);
      tbl.push_back(texel_item(24'h80FF01)); hf.push_back(0); fx.push_back(r0);
      tbl.push_back(texel_item(24'h123456)); hf.push_back(0); fx.push_back(r0);
      tbl.push_back(pixel_item(16'd0, 16'd0, 16'd0)); hf.push_back(0); fx.push_back(r0);
      r0 = '0; r0.kind = pds_pkg::KIND_DISCARD;
      tbl.push_back(texel_item(24'hFFFFFF)); hf.push_back(1); fx.push_back(r0);
      r0 = '0;
      tbl.push_back({pds_pkg::CMD_UNUSED, 154'h0}); hf.push_back(0); fx.push_back(r0);
      tbl.push_back({pds_pkg::CMD_UNUSED, {154{1'b1}}}); hf.push_back(0); fx.push_back(r0);
      foreach (tbl[i]) send(tbl[i], hf[i], fx[i]);
      drain();

      csr_write(pds_pkg::REG_LIGHT_X, 16'sh7FFF);
      csr_write(pds_pkg::REG_LIGHT_Y, 16'sh8000);
      csr_write(pds_pkg::REG_LIGHT_Z, 16'sh7FFF);
      random_phase(110);
      drain();

      send_idle = 75;
      csr_write(pds_pkg::REG_LIGHT_X, 16'sh8000);
      csr_write(pds_pkg::REG_LIGHT_Y, 16'sh7FFF);
      csr_write(pds_pkg::REG_LIGHT_Z, 16'sh8000);
      random_phase(110);
      drain();

      send_idle = 0; recv_stall = 75;
      csr_write(pds_pkg::REG_LIGHT_X, 16'($urandom));
      csr_write(pds_pkg::REG_LIGHT_Y, 16'($urandom));
      csr_write(pds_pkg::REG_LIGHT_Z, 16'($urandom));
      random_phase(110);
      drain();

      send_idle = 26; recv_stall = 26;
      csr_write(pds_pkg::REG_LIGHT_X, 16'sd0);
      csr_write(pds_pkg::REG_LIGHT_Y, 16'sd0);
      csr_write(pds_pkg::REG_LIGHT_Z, pds_pkg::LIGHT_Z_RESET);
      random_phase(110);
      drain();

      if (errors == 0 && shade_queue.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
